>>> hw/rtl/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

    localparam int ANGLE_WIDTH_DEF     = 32;
    localparam int VALUE_FRAC_BITS_DEF = 30;

    localparam int WF      = 56;
    localparam int MQ_W    = 64;
    localparam int OP_W    = 62;
    localparam int LO_W    = 31;
    localparam int HI_W    = OP_W - LO_W;
    localparam int PROD_W  = 2 * OP_W;
    localparam int N_STEPS = 4;
    localparam int NSTAGE  = 20;

    typedef logic signed [OP_W-1:0] t_op;
    typedef logic [MQ_W-1:0]        t_mq;

    typedef struct packed {
        logic req;
        t_op  x;
        t_op  x2;
    } t_side;

    localparam t_mq PI_MQ     = 64'h0324_3F6A_8885_A309;
    localparam t_mq TWO_PI_MQ = 64'h0648_7ED5_110B_4612;
    localparam t_mq ONE_MQ    = t_mq'(1) << WF;

    localparam t_op PI_OP     = t_op'(PI_MQ);
    localparam t_op TWO_PI_OP = t_op'(TWO_PI_MQ);
    localparam t_op ONE_OP    = t_op'(ONE_MQ);

    localparam int MAX_TURNS = int'(((t_mq'(1) << (MQ_W - 1)) + PI_MQ) / TWO_PI_MQ);

    typedef logic [MAX_TURNS-1:0][MQ_W-1:0] t_turn_tbl;

    function automatic t_turn_tbl turn_thr();
        t_turn_tbl tbl;
        for (int k = 0; k < MAX_TURNS; k++) begin
            tbl[k] = t_mq'(2 * k + 1) * PI_MQ;
        end
        return tbl;
    endfunction

    function automatic t_turn_tbl turn_prod();
        t_turn_tbl tbl;
        for (int k = 0; k < MAX_TURNS; k++) begin
            tbl[k] = t_mq'(k + 1) * TWO_PI_MQ;
        end
        return tbl;
    endfunction

    localparam t_turn_tbl TURN_THR  = turn_thr();
    localparam t_turn_tbl TURN_PROD = turn_prod();

    localparam t_op C_R2      = t_op'((ONE_MQ + t_mq'(1)) / t_mq'(2));
    localparam t_op C_R6      = t_op'((ONE_MQ + t_mq'(3)) / t_mq'(6));
    localparam t_op C_R24     = t_op'((ONE_MQ + t_mq'(12)) / t_mq'(24));
    localparam t_op C_R120    = t_op'((ONE_MQ + t_mq'(60)) / t_mq'(120));
    localparam t_op C_R720    = t_op'((ONE_MQ + t_mq'(360)) / t_mq'(720));
    localparam t_op C_R5040   = t_op'((ONE_MQ + t_mq'(2520)) / t_mq'(5040));
    localparam t_op C_R40320  = t_op'((ONE_MQ + t_mq'(20160)) / t_mq'(40320));
    localparam t_op C_R362880 = t_op'((ONE_MQ + t_mq'(181440)) / t_mq'(362880));

    typedef logic [N_STEPS-1:0][OP_W-1:0] t_coef_tbl;

    localparam t_coef_tbl SIN_C = {ONE_OP, C_R6, C_R120, C_R5040};
    localparam t_coef_tbl COS_C = {ONE_OP, C_R2, C_R24, C_R720};

    localparam t_op SIN_LEAD = C_R362880;
    localparam t_op COS_LEAD = C_R40320;

endpackage

>>> hw/rtl/sine_cosine_polynomial_core.sv
`timescale 1ns / 1ps
// channel | handshake           | beat fields
// --------+---------------------+--------------------------------------------
// input   | i_valid / o_stall   | i_req_type (0 sine, 1 cosine), i_angle Q8.24
// output  | o_valid / i_stall   | o_value Q2.30
//
// One beat per cycle while o_stall is low; o_valid rises once the beat has passed the stages below.
// 20 pipeline stages lead into the output register: 4 for angle reduction, 2 for the
// square, 3 for each of four Horner steps (partial products, sum and round, subtract)
// and 2 for the final product with x.
// Reset clears only the valid bits, those of the output buffer included.
// A two-entry output buffer keeps input beats flowing while a result waits;
// o_stall rises only once its second entry is taken and then holds the pipe.

module sine_cosine_polynomial_core #(
    parameter int ANGLE_WIDTH     = scp_pkg::ANGLE_WIDTH_DEF,
    parameter int VALUE_FRAC_BITS = scp_pkg::VALUE_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [VALUE_FRAC_BITS+1:0]    o_value
);

    localparam int NSTAGE  = scp_pkg::NSTAGE;
    localparam int N_STEPS = scp_pkg::N_STEPS;

    logic                 w_hold;
    logic                 w_en;
    logic [NSTAGE-1:0]    r_vld;
    logic                 w_red_req;
    scp_pkg::t_op         w_red_x;
    scp_pkg::t_op         w_x2;
    logic                 r_req_a;
    logic                 r_req_b;
    scp_pkg::t_op         r_x_a;
    scp_pkg::t_op         r_x_b;
    scp_pkg::t_side       w_side [N_STEPS+1];
    scp_pkg::t_op         w_s    [N_STEPS+1];
    scp_pkg::t_op         w_sx;
    logic                 r_req_c;
    logic                 r_req_d;
    scp_pkg::t_op         r_s_c;
    scp_pkg::t_op         r_s_d;
    scp_pkg::t_op         w_y;

    assign w_en    = !w_hold;
    assign o_stall = w_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_valid};
        end
    end

    scp_reduce #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_req   (i_req_type),
        .i_angle (i_angle),
        .o_req   (w_red_req),
        .o_x     (w_red_x)
    );

    scp_fmul u_square (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_red_x),
        .i_b   (w_red_x),
        .o_p   (w_x2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req_a <= w_red_req;
            r_x_a   <= w_red_x;
            r_req_b <= r_req_a;
            r_x_b   <= r_x_a;
        end
    end

    assign w_side[0] = '{req: r_req_b, x: r_x_b, x2: w_x2};
    assign w_s[0]    = r_req_b ? scp_pkg::COS_LEAD : scp_pkg::SIN_LEAD;

    for (genvar k = 0; k < N_STEPS; k++) begin : g_step
        scp_pkg::t_op w_c;

        assign w_c = w_side[k].req ? scp_pkg::COS_C[k] : scp_pkg::SIN_C[k];

        scp_horner u_step (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_side (w_side[k]),
            .i_s    (w_s[k]),
            .i_c    (w_c),
            .o_side (w_side[k+1]),
            .o_s    (w_s[k+1])
        );
    end

    scp_fmul u_final (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_side[N_STEPS].x),
        .i_b   (w_s[N_STEPS]),
        .o_p   (w_sx)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req_c <= w_side[N_STEPS].req;
            r_s_c   <= w_s[N_STEPS];
            r_req_d <= r_req_c;
            r_s_d   <= r_s_c;
        end
    end

    assign w_y = r_req_d ? r_s_d : w_sx;

    scp_outq #(
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[NSTAGE-1]),
        .i_y     (w_y),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_value (o_value),
        .o_hold  (w_hold)
    );

endmodule

>>> hw/rtl/scp_fmul.sv
`timescale 1ns / 1ps

module scp_fmul (
    input  logic          i_clk,
    input  logic          i_en,
    input  scp_pkg::t_op  i_a,
    input  scp_pkg::t_op  i_b,
    output scp_pkg::t_op  o_p
);

    localparam int LO_W   = scp_pkg::LO_W;
    localparam int HI_W   = scp_pkg::HI_W;
    localparam int OP_W   = scp_pkg::OP_W;
    localparam int PROD_W = scp_pkg::PROD_W;
    localparam int WF     = scp_pkg::WF;

    logic signed [LO_W:0]          w_a_lo;
    logic signed [LO_W:0]          w_b_lo;
    logic signed [HI_W-1:0]        w_a_hi;
    logic signed [HI_W-1:0]        w_b_hi;
    logic [2*LO_W-1:0]             n_ll;
    logic signed [LO_W+HI_W:0]     n_lh;
    logic signed [LO_W+HI_W:0]     n_hl;
    logic signed [2*HI_W-1:0]      n_hh;
    logic [2*LO_W-1:0]             r_ll;
    logic signed [LO_W+HI_W:0]     r_lh;
    logic signed [LO_W+HI_W:0]     r_hl;
    logic signed [2*HI_W-1:0]      r_hh;
    logic                          r_neg;
    logic signed [PROD_W-1:0]      w_ll;
    logic signed [PROD_W-1:0]      w_lh;
    logic signed [PROD_W-1:0]      w_hl;
    logic signed [PROD_W-1:0]      w_hh;
    logic signed [PROD_W-1:0]      w_rnd;
    logic signed [PROD_W-1:0]      w_sum;
    scp_pkg::t_op                  n_p;
    scp_pkg::t_op                  r_p;

    assign w_a_lo = signed'({1'b0, i_a[LO_W-1:0]});
    assign w_b_lo = signed'({1'b0, i_b[LO_W-1:0]});
    assign w_a_hi = i_a[OP_W-1:LO_W];
    assign w_b_hi = i_b[OP_W-1:LO_W];

    assign n_ll = i_a[LO_W-1:0] * i_b[LO_W-1:0];
    assign n_lh = w_a_lo * w_b_hi;
    assign n_hl = w_a_hi * w_b_lo;
    assign n_hh = w_a_hi * w_b_hi;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= n_ll;
            r_lh  <= n_lh;
            r_hl  <= n_hl;
            r_hh  <= n_hh;
            r_neg <= i_a[OP_W-1] ^ i_b[OP_W-1];
        end
    end

    // round half away from zero: negative products take one less
    assign w_ll  = PROD_W'(r_ll);
    assign w_lh  = PROD_W'(r_lh);
    assign w_hl  = PROD_W'(r_hl);
    assign w_hh  = PROD_W'(r_hh);
    assign w_rnd = (PROD_W'(1) <<< (WF - 1)) - PROD_W'(r_neg);
    assign w_sum = (w_hh <<< (2 * LO_W)) + ((w_lh + w_hl) <<< LO_W) + w_ll + w_rnd;
    assign n_p   = w_sum[WF+OP_W-1:WF];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

>>> hw/rtl/scp_reduce.sv
`timescale 1ns / 1ps

module scp_reduce #(
    parameter int ANGLE_WIDTH = scp_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_req,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic                          o_req,
    output scp_pkg::t_op                  o_x
);

    localparam int MQ_W      = scp_pkg::MQ_W;
    localparam int OP_W      = scp_pkg::OP_W;
    localparam int MAX_TURNS = scp_pkg::MAX_TURNS;
    localparam int FILL_W    = MQ_W - ANGLE_WIDTH;

    logic [ANGLE_WIDTH-1:0] w_raw;
    logic                   w_neg;
    logic [ANGLE_WIDTH-1:0] w_mag;
    scp_pkg::t_mq           n1_mq;
    logic                   r1_neg;
    logic                   r1_req;
    scp_pkg::t_mq           r1_mq;

    logic [MAX_TURNS-1:0]   n2_thr;
    logic [MAX_TURNS-1:0]   r2_thr;
    logic                   r2_neg;
    logic                   r2_req;
    scp_pkg::t_mq           r2_mq;

    logic [MAX_TURNS:0]     w_thr_x;
    scp_pkg::t_mq           w_prod;
    logic [MQ_W:0]          w_diff;
    scp_pkg::t_op           n3_x;
    scp_pkg::t_op           r3_x;
    logic                   r3_req;

    scp_pkg::t_op           n4_x;
    scp_pkg::t_op           r4_x;
    logic                   r4_req;

    assign w_raw = i_angle;
    assign w_neg = w_raw[ANGLE_WIDTH-1];
    assign w_mag = w_neg ? ({ANGLE_WIDTH{1'b0}} - w_raw) : w_raw;
    assign n1_mq = {w_mag, {FILL_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg <= w_neg;
            r1_req <= i_req;
            r1_mq  <= n1_mq;
        end
    end

    // exactly pi stays unreduced
    always_comb begin
        for (int k = 0; k < MAX_TURNS; k++) begin
            if (k == 0) begin
                n2_thr[k] = r1_mq > scp_pkg::TURN_THR[k];
            end else begin
                n2_thr[k] = r1_mq >= scp_pkg::TURN_THR[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_thr <= n2_thr;
            r2_neg <= r1_neg;
            r2_req <= r1_req;
            r2_mq  <= r1_mq;
        end
    end

    assign w_thr_x = {1'b0, r2_thr};

    always_comb begin
        w_prod = '0;
        for (int k = 0; k < MAX_TURNS; k++) begin
            if (w_thr_x[k] && !w_thr_x[k+1]) begin
                w_prod = w_prod | scp_pkg::TURN_PROD[k];
            end
        end
    end

    assign w_diff = r2_neg ? ({1'b0, w_prod} - {1'b0, r2_mq})
                           : ({1'b0, r2_mq} - {1'b0, w_prod});
    assign n3_x   = w_diff[OP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_x   <= n3_x;
            r3_req <= r2_req;
        end
    end

    always_comb begin
        if (r3_x > scp_pkg::PI_OP) begin
            n4_x = r3_x - scp_pkg::TWO_PI_OP;
        end else if (r3_x < -scp_pkg::PI_OP) begin
            n4_x = r3_x + scp_pkg::TWO_PI_OP;
        end else begin
            n4_x = r3_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_x   <= n4_x;
            r4_req <= r3_req;
        end
    end

    assign o_x   = r4_x;
    assign o_req = r4_req;

endmodule

>>> hw/rtl/scp_horner.sv
`timescale 1ns / 1ps

module scp_horner (
    input  logic            i_clk,
    input  logic            i_en,
    input  scp_pkg::t_side  i_side,
    input  scp_pkg::t_op    i_s,
    input  scp_pkg::t_op    i_c,
    output scp_pkg::t_side  o_side,
    output scp_pkg::t_op    o_s
);

    scp_pkg::t_op   w_p;
    scp_pkg::t_side r_side1;
    scp_pkg::t_side r_side2;
    scp_pkg::t_side r_side3;
    scp_pkg::t_op   r_c1;
    scp_pkg::t_op   r_c2;
    scp_pkg::t_op   n_s;
    scp_pkg::t_op   r_s;

    scp_fmul u_mul (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_side.x2),
        .i_b   (i_s),
        .o_p   (w_p)
    );

    assign n_s = r_c2 - w_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
            r_c1    <= i_c;
            r_c2    <= r_c1;
            r_s     <= n_s;
        end
    end

    assign o_side = r_side3;
    assign o_s    = r_s;

endmodule

>>> hw/rtl/scp_outq.sv
`timescale 1ns / 1ps

module scp_outq #(
    parameter int VALUE_FRAC_BITS = scp_pkg::VALUE_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  scp_pkg::t_op                  i_y,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [VALUE_FRAC_BITS+1:0]    o_value,
    output logic                          o_hold
);

    localparam int OP_W = scp_pkg::OP_W;
    localparam int VW   = VALUE_FRAC_BITS + 2;
    localparam int SH   = scp_pkg::WF - VALUE_FRAC_BITS;
    localparam int VF_W = OP_W + 1 - SH;

    logic signed [OP_W:0]   w_ye;
    logic signed [OP_W:0]   w_sum;
    logic signed [VF_W-1:0] w_full;
    logic                   w_ovf;
    logic [VW-1:0]          w_val;
    logic                   w_take;
    logic                   w_in;
    logic                   n_o_vld;
    logic                   n_k_vld;
    logic [VW-1:0]          n_o_val;
    logic [VW-1:0]          n_k_val;
    logic                   r_o_vld;
    logic                   r_k_vld;
    logic [VW-1:0]          r_o_val;
    logic [VW-1:0]          r_k_val;

    assign w_ye   = (OP_W + 1)'(i_y);
    assign w_sum  = w_ye + ((OP_W + 1)'(1) <<< (SH - 1)) - (OP_W + 1)'(i_y[OP_W-1]);
    assign w_full = w_sum[OP_W:SH];
    assign w_ovf  = w_full[VF_W-1:VW-1] != {(VF_W - VW + 1){w_full[VF_W-1]}};
    assign w_val  = w_ovf ? {w_full[VF_W-1], {(VW - 1){~w_full[VF_W-1]}}} : w_full[VW-1:0];

    assign w_take = r_o_vld && !i_stall;
    assign w_in   = i_valid && !r_k_vld;

    always_comb begin
        n_o_vld = r_o_vld && !w_take;
        n_k_vld = r_k_vld;
        n_o_val = r_o_val;
        n_k_val = r_k_val;
        if (r_k_vld) begin
            if (w_take) begin
                n_o_vld = 1'b1;
                n_o_val = r_k_val;
                n_k_vld = 1'b0;
            end
        end else if (w_in) begin
            if (!r_o_vld || w_take) begin
                n_o_vld = 1'b1;
                n_o_val = w_val;
            end else begin
                n_k_vld = 1'b1;
                n_k_val = w_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_k_vld <= 1'b0;
        end else begin
            r_o_vld <= n_o_vld;
            r_k_vld <= n_k_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_val <= n_o_val;
        r_k_val <= n_k_val;
    end

    assign o_valid = r_o_vld;
    assign o_value = r_o_val;
    assign o_hold  = r_k_vld;

endmodule

>>> dv/tb_sine_cosine_polynomial_core.sv
`timescale 1ns / 1ps

module tb_sine_cosine_polynomial_core;

    localparam int AW   = scp_pkg::ANGLE_WIDTH_DEF;
    localparam int VFB  = scp_pkg::VALUE_FRAC_BITS_DEF;
    localparam int VW   = VFB + 2;
    localparam int FRAC = 56;

    localparam int RANDOM_ITEMS = 500;
    localparam int CHUNKS       = 8;
    localparam int MAX_GAP      = 30;
    localparam int DRAIN_CYCLES = 40;

    localparam bit [63:0] ONE_U    = 64'd1 << FRAC;
    localparam bit [63:0] PI_U     = 64'h0324_3F6A_8885_A309;
    localparam bit [63:0] TWO_PI_U = 64'h0648_7ED5_110B_4612;
    localparam longint    PI_S     = PI_U;
    localparam longint    TWO_PI_S = TWO_PI_U;

    localparam longint INV_2      = (ONE_U + 64'd1) / 64'd2;
    localparam longint INV_6      = (ONE_U + 64'd3) / 64'd6;
    localparam longint INV_24     = (ONE_U + 64'd12) / 64'd24;
    localparam longint INV_120    = (ONE_U + 64'd60) / 64'd120;
    localparam longint INV_720    = (ONE_U + 64'd360) / 64'd720;
    localparam longint INV_5040   = (ONE_U + 64'd2520) / 64'd5040;
    localparam longint INV_40320  = (ONE_U + 64'd20160) / 64'd40320;
    localparam longint INV_362880 = (ONE_U + 64'd181440) / 64'd362880;

    typedef enum bit {
        REQ_SINE   = 1'b0,
        REQ_COSINE = 1'b1
    } req_e;

    typedef enum int {
        PHASE_STEADY,
        PHASE_SENDER_IDLE,
        PHASE_RECEIVER_STALL,
        PHASE_BOTH
    } phase_e;

    class scp_scoreboard;
        logic [VW-1:0] pending_values[$];
        int unsigned   errors;

        function longint mul_q56(longint a, longint b);
            bit         neg;
            bit [63:0]  ua;
            bit [63:0]  ub;
            bit [127:0] p;
            bit [63:0]  r;
            neg = (a < 0) != (b < 0);
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            p = {64'd0, ua} * {64'd0, ub};
            p = p + (128'd1 << (FRAC - 1));
            r = 64'(p >> FRAC);
            r[63:62] = 2'b00;
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function longint reduce_angle(bit [AW-1:0] raw);
            bit        neg;
            bit [63:0] m;
            bit [63:0] mq;
            bit [63:0] turns;
            bit [63:0] whole;
            longint    r;
            longint    x;
            neg = raw[AW-1];
            m = neg ? ((64'd1 << AW) - 64'(raw)) : 64'(raw);
            mq = m << (FRAC - (AW - 8));
            if (mq > PI_U) begin
                turns = (mq + TWO_PI_U / 64'd2) / TWO_PI_U;
                whole = turns * TWO_PI_U;
                r = (mq >= whole) ? longint'(mq - whole) : -longint'(whole - mq);
                x = neg ? -r : r;
            end else begin
                x = neg ? -longint'(mq) : longint'(mq);
            end
            if (x > PI_S) begin
                x = x - TWO_PI_S;
            end else if (x < -PI_S) begin
                x = x + TWO_PI_S;
            end
            return x;
        endfunction

        function logic [VW-1:0] predict_value(req_e req, bit [AW-1:0] angle);
            longint    x;
            longint    x2;
            longint    s;
            longint    y;
            bit [63:0] ym;
            bit [63:0] vm;
            bit [63:0] vmax;
            x = reduce_angle(angle);
            x2 = mul_q56(x, x);
            if (req == REQ_SINE) begin
                s = INV_5040 - mul_q56(x2, INV_362880);
                s = INV_120 - mul_q56(x2, s);
                s = INV_6 - mul_q56(x2, s);
                s = longint'(ONE_U) - mul_q56(x2, s);
                y = mul_q56(x, s);
            end else begin
                s = INV_720 - mul_q56(x2, INV_40320);
                s = INV_24 - mul_q56(x2, s);
                s = INV_2 - mul_q56(x2, s);
                y = longint'(ONE_U) - mul_q56(x2, s);
            end
            ym = (y < 0) ? -y : y;
            vm = (ym + (64'd1 << (FRAC - VFB - 1))) >> (FRAC - VFB);
            vmax = 64'd1 << (VW - 1);
            if (y < 0) begin
                if (vm > vmax) begin
                    vm = vmax;
                end
                vm = -vm;
            end else if (vm > vmax - 64'd1) begin
                vm = vmax - 64'd1;
            end
            return vm[VW-1:0];
        endfunction

        function void note_angle(req_e req, bit [AW-1:0] angle);
            pending_values.push_back(predict_value(req, angle));
        endfunction

        function void check_value(logic [VW-1:0] value);
            logic [VW-1:0] want;
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, value);
                errors++;
            end else begin
                want = pending_values.pop_front();
                if (value !== want) begin
                    $display("%0t: value mismatch, expected %h, got %h", $time, want, value);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_req_type;
    logic signed [AW-1:0] i_angle;
    logic                 o_valid;
    logic                 i_stall;
    logic [VW-1:0]        o_value;

    scp_scoreboard sb = new();
    int unsigned   snd_idle_pct;
    int unsigned   rcv_stall_pct;

    sine_cosine_polynomial_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_angle    (i_angle),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_angle(req_e'(i_req_type), i_angle);
            end
            if (o_valid && !i_stall) begin
                sb.check_value(o_value);
            end
        end
    end

    function automatic bit [AW-1:0] near_pi_multiple(int unsigned k, int delta);
        bit [63:0] p;
        p = 64'(k) * PI_U;
        return AW'(p >> 32) + AW'(delta);
    endfunction

    function automatic bit [AW-1:0] random_angle();
        int unsigned pick;
        bit [AW-1:0] a;
        pick = $urandom_range(9);
        if (pick < 5) begin
            a = $urandom;
        end else if (pick < 8) begin
            a = $urandom_range(32'h0324_3F6B);
        end else begin
            a = near_pi_multiple($urandom_range(1, 40), int'($urandom_range(6)) - 3);
        end
        if ($urandom_range(1)) begin
            a = -a;
        end
        return a;
    endfunction

    task automatic set_phase(phase_e ph);
        snd_idle_pct  = (ph == PHASE_SENDER_IDLE) ? 71 : (ph == PHASE_BOTH) ? 19 : 0;
        rcv_stall_pct = (ph == PHASE_RECEIVER_STALL) ? 71 : (ph == PHASE_BOTH) ? 19 : 0;
    endtask

    task automatic send_angle(req_e req, bit [AW-1:0] angle);
        int unsigned gap;
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_angle    <= angle;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < snd_idle_pct) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        bit [AW-1:0] directed[$];
        int unsigned per_chunk;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_req_type <= REQ_SINE;
        i_angle    <= '0;
        i_stall    <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{'0, AW'(1), '1, {1'b0, {(AW-1){1'b1}}}, {1'b1, {(AW-1){1'b0}}},
                     near_pi_multiple(1, 0), near_pi_multiple(1, 1),
                     -near_pi_multiple(1, 0), -near_pi_multiple(1, 1),
                     near_pi_multiple(3, 0), near_pi_multiple(3, 1),
                     near_pi_multiple(2, 0)};
        set_phase(PHASE_STEADY);
        foreach (directed[i]) begin
            send_angle(REQ_SINE, directed[i]);
            send_angle(REQ_COSINE, directed[i]);
        end

        per_chunk = RANDOM_ITEMS / CHUNKS;
        for (int c = 0; c < CHUNKS; c++) begin
            set_phase(phase_e'(c % 4));
            repeat (per_chunk) begin
                send_angle(req_e'($urandom_range(1)), random_angle());
            end
        end
        i_valid <= 1'b0;

        while (sb.pending_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_sine_cosine_polynomial_core passed");
        end else begin
            $display("tb_sine_cosine_polynomial_core failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_sine_cosine_polynomial_core failed");
        $finish;
    end

endmodule
